[sv/nwsa_pkg.sv]
// Shared types, constants and codes of the net weight scatter-accumulate unit
`timescale 1ns / 1ps

package nwsa_pkg;

  // sizes of the two stores and the field widths
  localparam int NODE_COUNT  = 4096;
  localparam int PIN_COUNT   = 16384;
  localparam int TOTAL_WIDTH = 48;
  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int PIN_W       = $clog2(PIN_COUNT);
  localparam int WEIGHT_W    = 32;

  typedef logic [PIN_W-1:0]               pin_t;
  typedef logic [NODE_W-1:0]              node_t;
  typedef logic signed [WEIGHT_W-1:0]     weight_t;
  typedef logic signed [TOTAL_WIDTH-1:0]  total_t;

  localparam total_t TOTAL_MAX = {1'b0, {(TOTAL_WIDTH-1){1'b1}}};
  localparam total_t TOTAL_MIN = {1'b1, {(TOTAL_WIDTH-1){1'b0}}};
  localparam node_t  NODE_LAST = node_t'(NODE_COUNT - 1);

  // request codes
  typedef enum logic [1:0] {
    REQ_MAP_LOAD = 2'd0,
    REQ_ADD_NET  = 2'd1,
    REQ_READ     = 2'd2,
    REQ_PRELOAD  = 2'd3
  } req_type_t;

  // controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP_WR,
    ST_RD,
    ST_RD_OUT,
    ST_PRE,
    ST_NET_A,
    ST_NET_B,
    ST_NET_C,
    ST_DONE_OUT
  } state_t;

  // one request as captured by the datapath
  typedef struct packed {
    req_type_t req_type;
    pin_t      first_pin;
    pin_t      second_pin;
    node_t     node_id;
    weight_t   net_weight;
    total_t    preload_value;
    logic      last_net;
  } req_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;   // register the request, look up both pins
    logic map_wr;    // write the pin map entry
    logic net_rd_a;  // read accumulator of the source node
    logic net_wr_a;  // update source node, read destination node
    logic net_wr_b;  // update destination node
    logic rd_node;   // read the requested node total
    logic pre_wr;    // overwrite the requested node total
    logic clr_wr;    // clearing pass write
    logic out_load;  // load the output register
    logic out_done;  // the loaded result is a done result
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
    logic req_last;
  } sts_t;

endpackage

[sv/nwsa_if.sv]
// Request and result channel interfaces of the net weight scatter-accumulate unit
`timescale 1ns / 1ps

interface nwsa_in_if;
  import nwsa_pkg::*;

  logic         valid;
  logic         ready;
  logic [1:0]   req_type;
  pin_t         first_pin;
  pin_t         second_pin;
  node_t        node_id;
  weight_t      net_weight;
  total_t       preload_value;
  logic         last_net;

  modport source (
    output valid, req_type, first_pin, second_pin, node_id, net_weight,
           preload_value, last_net,
    input  ready
  );
  modport sink (
    input  valid, req_type, first_pin, second_pin, node_id, net_weight,
           preload_value, last_net,
    output ready
  );
  modport mon (
    input valid, ready, req_type, first_pin, second_pin, node_id, net_weight,
          preload_value, last_net
  );
endinterface

interface nwsa_out_if;
  import nwsa_pkg::*;

  logic   valid;
  logic   ready;
  total_t node_total;
  logic   batch_done;

  modport source (
    output valid, node_total, batch_done,
    input  ready
  );
  modport sink (
    input  valid, node_total, batch_done,
    output ready
  );
  modport mon (
    input valid, ready, node_total, batch_done
  );
endinterface

[sv/net_weight_scatter_accumulate_unit.sv]
// Top level of the net weight scatter-accumulate unit
`timescale 1ns / 1ps

// Keeps a 16384-entry pin-to-node map and 4096 signed Q32.16 node totals and
// serves one request at a time. After reset a clearing pass zeroes all node
// totals, one per cycle; no request is taken meanwhile. A map load captures
// the request, then writes the map entry; a preload likewise writes the node
// total; a read captures, reads the total and waits for the result register;
// an add-net looks up both pins, then on the single accumulator memory port
// reads the source total, writes it back while reading the destination total
// and writes that one. A last net may then wait for the result register.
// Each addition saturates at the Q32.16 range; a net whose two pins share a
// node adds its weight to that node twice. A net marked last returns one done
// result with a zero total. Results wait in an output register, so a new
// request is taken while an earlier result is still unread. Reading a pin map
// entry that was never written gives an undefined node.
module net_weight_scatter_accumulate_unit (
  input  logic         clk,
  input  logic         rst_n,
  nwsa_in_if.sink      in_req,
  nwsa_out_if.source   out_res
);
  import nwsa_pkg::*;

  cmd_t cmd;
  sts_t sts;
  req_t req;

  // request payload as one struct
  assign req.req_type      = req_type_t'(in_req.req_type);
  assign req.first_pin     = in_req.first_pin;
  assign req.second_pin    = in_req.second_pin;
  assign req.node_id       = in_req.node_id;
  assign req.net_weight    = in_req.net_weight;
  assign req.preload_value = in_req.preload_value;
  assign req.last_net      = in_req.last_net;

  // controller
  nwsa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_req_type (in_req.req_type),
    .in_ready    (in_req.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // datapath
  nwsa_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req         (req),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_res.ready),
    .out_valid      (out_res.valid),
    .out_node_total (out_res.node_total),
    .out_batch_done (out_res.batch_done)
  );

endmodule

[sv/nwsa_ctrl.sv]
// Controller state machine of the net weight scatter-accumulate unit
`timescale 1ns / 1ps

module nwsa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_req_type,
  output logic            in_ready,
  input  nwsa_pkg::sts_t  sts,
  output nwsa_pkg::cmd_t  cmd
);
  import nwsa_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register, clearing pass first after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (req_type_t'(in_req_type))
            REQ_MAP_LOAD: state_nxt = ST_MAP_WR;
            REQ_ADD_NET:  state_nxt = ST_NET_A;
            REQ_READ:     state_nxt = ST_RD;
            REQ_PRELOAD:  state_nxt = ST_PRE;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MAP_WR: begin
        cmd.map_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_RD: begin
        cmd.rd_node = 1'b1;
        state_nxt   = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_PRE: begin
        cmd.pre_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_NET_A: begin
        cmd.net_rd_a = 1'b1;
        state_nxt    = ST_NET_B;
      end
      ST_NET_B: begin
        cmd.net_wr_a = 1'b1;
        state_nxt    = ST_NET_C;
      end
      ST_NET_C: begin
        cmd.net_wr_b = 1'b1;
        if (!sts.req_last) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_done = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_DONE_OUT;
        end
      end
      ST_DONE_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_done = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/nwsa_datapath.sv]
// Pin map, node accumulator memory, saturating adder and result register
`timescale 1ns / 1ps

module nwsa_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  nwsa_pkg::req_t      in_req,
  input  nwsa_pkg::cmd_t      cmd,
  output nwsa_pkg::sts_t      sts,
  input  logic                out_ready,
  output logic                out_valid,
  output nwsa_pkg::total_t    out_node_total,
  output logic                out_batch_done
);
  import nwsa_pkg::*;

  // storage
  node_t  pin_map [PIN_COUNT];
  total_t node_mem [NODE_COUNT];

  req_t   req_r;
  node_t  node_a_r;
  node_t  node_b_r;
  total_t tot_q_r;
  total_t wr_a_val_r;
  node_t  clr_cnt_r;
  logic   out_valid_r;
  total_t out_total_r;
  logic   out_done_r;

  logic   tot_rd_en;
  node_t  tot_rd_addr;
  logic   tot_wr_en;
  node_t  tot_wr_addr;
  total_t tot_wr_data;
  total_t sum_a;
  total_t sum_b;
  logic   same_node;

  // add a weight to a total, clamped to the accumulator range
  function automatic total_t sat_add(total_t acc, weight_t w);
    logic [TOTAL_WIDTH:0] sum;
    sum = {acc[TOTAL_WIDTH-1], acc} + {{(TOTAL_WIDTH+1-WEIGHT_W){w[WEIGHT_W-1]}}, w};
    if (sum[TOTAL_WIDTH] != sum[TOTAL_WIDTH-1]) begin
      return sum[TOTAL_WIDTH] ? TOTAL_MIN : TOTAL_MAX;
    end
    return total_t'(sum[TOTAL_WIDTH-1:0]);
  endfunction

  // request capture and pin lookups
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r    <= in_req;
      node_a_r <= pin_map[in_req.first_pin];
      node_b_r <= pin_map[in_req.second_pin];
    end
    if (cmd.map_wr) begin
      pin_map[req_r.first_pin] <= req_r.node_id;
    end
  end

  // both pins on one node: destination update sees the source update
  assign same_node = (node_a_r == node_b_r);
  assign sum_a     = sat_add(tot_q_r, req_r.net_weight);
  assign sum_b     = sat_add(same_node ? wr_a_val_r : tot_q_r, req_r.net_weight);

  // accumulator memory port selection
  always_comb begin
    tot_rd_en   = cmd.net_rd_a | cmd.net_wr_a | cmd.rd_node;
    tot_rd_addr = req_r.node_id;
    if (cmd.net_rd_a) begin
      tot_rd_addr = node_a_r;
    end else if (cmd.net_wr_a) begin
      tot_rd_addr = node_b_r;
    end

    tot_wr_en   = cmd.clr_wr | cmd.pre_wr | cmd.net_wr_a | cmd.net_wr_b;
    tot_wr_addr = clr_cnt_r;
    tot_wr_data = '0;
    if (cmd.pre_wr) begin
      tot_wr_addr = req_r.node_id;
      tot_wr_data = req_r.preload_value;
    end else if (cmd.net_wr_a) begin
      tot_wr_addr = node_a_r;
      tot_wr_data = sum_a;
    end else if (cmd.net_wr_b) begin
      tot_wr_addr = node_b_r;
      tot_wr_data = sum_b;
    end
  end

  // accumulator memory, registered read held between reads
  always_ff @(posedge clk) begin
    if (tot_rd_en) begin
      tot_q_r <= node_mem[tot_rd_addr];
    end
    if (tot_wr_en) begin
      node_mem[tot_wr_addr] <= tot_wr_data;
    end
    if (cmd.net_wr_a) begin
      wr_a_val_r <= sum_a;
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + node_t'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_total_r <= cmd.out_done ? '0 : tot_q_r;
      out_done_r  <= cmd.out_done;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_node_total = out_total_r;
  assign out_batch_done = out_done_r;

  // status
  assign sts.clr_last = (clr_cnt_r == NODE_LAST);
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.req_last = req_r.last_net;

endmodule

[sv/nwsa_checker.sv]
// Port-level checks of the net weight scatter-accumulate unit and their binding
`timescale 1ns / 1ps

module nwsa_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input nwsa_pkg::total_t  out_node_total,
  input logic              out_batch_done
);

  // a pending result stays until taken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // one request at a time: no request taken in the cycle after one
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  // a done result carries a zero total
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_batch_done |-> out_node_total == '0)
    else $error("done result with nonzero total");

  // a new result is only produced while a request is in work
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared with no request in work");

endmodule

bind net_weight_scatter_accumulate_unit nwsa_checker u_nwsa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .out_node_total (out_res.node_total),
  .out_batch_done (out_res.batch_done)
);
